### hdl/memory_lcd_frame_controller_top_assert.svh
// assertion macros for the memory lcd frame controller checker
`ifndef MEMORY_LCD_FRAME_CONTROLLER_TOP_ASSERT_SVH
`define MEMORY_LCD_FRAME_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define MLCD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define MLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/mlcd_pkg.sv
// shared constants, types and functions of the memory lcd frame controller
package mlcd_pkg;

    localparam int OP_W   = 3;
    localparam int X_W    = 9;
    localparam int Y_W    = 8;
    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;

    localparam int DEF_PANEL_WIDTH  = 400;
    localparam int DEF_PANEL_HEIGHT = 240;

    localparam logic [OP_W-1:0] OP_SET_PIXEL   = 3'd0;
    localparam logic [OP_W-1:0] OP_GET_PIXEL   = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR_STORE = 3'd2;
    localparam logic [OP_W-1:0] OP_REFRESH     = 3'd3;
    localparam logic [OP_W-1:0] OP_PANEL_CLEAR = 3'd4;

    localparam logic [KIND_W-1:0] KIND_SPI        = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PIXEL      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FRAME_DONE = 2'd2;

    localparam logic [BYTE_W-1:0] CMD_WRITE = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_VCOM  = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_CLEAR = 8'h04;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] spi_byte;
        logic              read_bit;
        logic              first;
        logic              last;
    } t_result;

    function automatic logic [BYTE_W-1:0] flip8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int b = 0; b < BYTE_W; b++) begin
            r[BYTE_W-1-b] = v[b];
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] hdr_byte(input logic [BYTE_W-1:0] cmd,
                                                   input logic vcom);
        return flip8(cmd | (vcom ? CMD_VCOM : 8'h00));
    endfunction

    function automatic t_result mk_result(input logic [KIND_W-1:0] kind,
                                          input logic [BYTE_W-1:0] spi_byte,
                                          input logic read_bit,
                                          input logic first,
                                          input logic last);
        t_result r;
        r.kind     = kind;
        r.spi_byte = spi_byte;
        r.read_bit = read_bit;
        r.first    = first;
        r.last     = last;
        return r;
    endfunction

endpackage

### hdl/mlcd_ram.sv
// generic single-clock ram, one write port and one registered read port
module mlcd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/memory_lcd_frame_controller_top.sv
// top level of the memory lcd frame controller: sequencer, frame store and row dirty ram
//
//  channel  | handshake           | words
//  ---------+---------------------+--------------------------------------------
//  command  | start / busy        | operation, pixel_x, pixel_y, pixel_on
//  result   | o_valid strobe      | result_kind, spi_byte, read_bit, first/last
//
// pixel set or get in range: address multiply, then store read, then modify/write
// refresh step: one spi word per command; a line byte takes a store read first, and a
// header or frame done follows a dirty search over the rows from the scan row on
// panel clear: header then tail, one word per cycle; others and ignored pixels stay idle
// reset and clear store sweep max(store bytes, rows) words, 12000 by default, busy held high
// results are strobed for one cycle and cannot be stalled
module memory_lcd_frame_controller_top #(
    parameter int PANEL_WIDTH  = mlcd_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = mlcd_pkg::DEF_PANEL_HEIGHT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mlcd_pkg::OP_W-1:0]   i_operation,
    input  logic [mlcd_pkg::X_W-1:0]    i_pixel_x,
    input  logic [mlcd_pkg::Y_W-1:0]    i_pixel_y,
    input  logic                        i_pixel_on,
    output logic                        o_valid,
    output logic [mlcd_pkg::KIND_W-1:0] o_result_kind,
    output logic [mlcd_pkg::BYTE_W-1:0] o_spi_byte,
    output logic                        o_read_bit,
    output logic                        o_first_of_transfer,
    output logic                        o_last_of_transfer
);

    import mlcd_pkg::*;

    localparam int ROW_BYTES   = PANEL_WIDTH / 8;
    localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
    localparam int FA_W        = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int DA_W        = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
    localparam int BIT_W       = $clog2(PANEL_WIDTH * PANEL_HEIGHT);
    localparam int FILL_DEPTH  = (STORE_BYTES > PANEL_HEIGHT) ? STORE_BYTES : PANEL_HEIGHT;
    localparam int FC_W        = (FILL_DEPTH > 1) ? $clog2(FILL_DEPTH) : 1;
    localparam int POS_W       = $clog2(ROW_BYTES + 4);
    localparam int POS_ADDR    = 1;
    localparam int POS_LINE0   = 2;
    localparam int POS_DUMMY0  = 2 + ROW_BYTES;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_PIX_RD,
        S_PIX_MOD,
        S_SRCH,
        S_SRCH_CHK,
        S_LINE,
        S_PCLR
    } t_state;

    t_state             r_state;
    logic [FC_W-1:0]    r_fill;
    logic               r_vcom;
    logic [Y_W-1:0]     r_scan_row;
    logic [POS_W-1:0]   r_byte_pos;
    logic               r_row_active;
    logic [Y_W-1:0]     r_row_ptr;
    logic [FA_W-1:0]    r_row_base;
    logic [BIT_W-1:0]   r_bit_idx;
    logic [Y_W-1:0]     r_y;
    logic               r_on;
    logic [OP_W-1:0]    r_op;
    logic               r_valid;
    t_result            r_res;

    logic               fs_we;
    logic [FA_W-1:0]    fs_waddr;
    logic [BYTE_W-1:0]  fs_wdata;
    logic               fs_re;
    logic [FA_W-1:0]    fs_raddr;
    logic [BYTE_W-1:0]  fs_q;
    logic               rd_we;
    logic [DA_W-1:0]    rd_waddr;
    logic               rd_wdata;
    logic               rd_re;
    logic [DA_W-1:0]    rd_raddr;
    logic               rd_q;

    logic               in_range;
    logic [BIT_W-1:0]   n_bit_idx;
    logic [BIT_W-1:0]   pix_byte;
    logic [FA_W-1:0]    pix_addr;
    logic [BIT_W-1:0]   row_mult;
    logic [FA_W-1:0]    n_row_base;
    logic [FA_W-1:0]    line_addr;
    logic               pos_is_line;
    logic               fill_in_store;
    logic               fill_in_rows;
    logic [BYTE_W-1:0]  bit_mask;
    logic [BYTE_W-1:0]  n_mod;

    assign in_range  = (i_pixel_x < X_W'(PANEL_WIDTH)) && (i_pixel_y < Y_W'(PANEL_HEIGHT));
    assign n_bit_idx = BIT_W'(i_pixel_y) * BIT_W'(PANEL_WIDTH) + BIT_W'(i_pixel_x);
    assign pix_byte  = r_bit_idx >> 3;
    assign pix_addr  = pix_byte[FA_W-1:0];
    assign row_mult  = BIT_W'(r_row_ptr) * BIT_W'(PANEL_WIDTH);
    assign n_row_base = FA_W'(row_mult >> 3);
    assign line_addr = r_row_base + FA_W'(r_byte_pos - POS_W'(POS_LINE0));
    assign pos_is_line = (r_byte_pos >= POS_W'(POS_LINE0)) &&
                         (r_byte_pos < POS_W'(POS_DUMMY0));
    assign fill_in_store = ({1'b0, r_fill} < (FC_W + 1)'(STORE_BYTES));
    assign fill_in_rows  = ({1'b0, r_fill} < (FC_W + 1)'(PANEL_HEIGHT));
    assign bit_mask  = 8'h01 << r_bit_idx[2:0];
    assign n_mod     = r_on ? (fs_q | bit_mask) : (fs_q & ~bit_mask);

    // memory port steering
    always_comb begin
        fs_we    = 1'b0;
        fs_waddr = pix_addr;
        fs_wdata = fs_q;
        fs_re    = 1'b0;
        fs_raddr = pix_addr;
        rd_we    = 1'b0;
        rd_waddr = r_y[DA_W-1:0];
        rd_wdata = 1'b1;
        rd_re    = 1'b0;
        rd_raddr = r_row_ptr[DA_W-1:0];
        unique case (r_state)
            S_FILL: begin
                fs_we    = fill_in_store;
                fs_waddr = r_fill[FA_W-1:0];
                fs_wdata = 8'hFF;
                rd_we    = fill_in_rows;
                rd_waddr = r_fill[DA_W-1:0];
            end
            S_IDLE: begin
                if (start && i_operation == OP_REFRESH && r_row_active && pos_is_line) begin
                    fs_re    = 1'b1;
                    fs_raddr = line_addr;
                end
                if (start && i_operation == OP_PANEL_CLEAR && r_row_active) begin
                    rd_we    = 1'b1;
                    rd_waddr = r_scan_row[DA_W-1:0];
                end
            end
            S_PIX_RD: begin
                fs_re = 1'b1;
            end
            S_PIX_MOD: begin
                if (r_op == OP_SET_PIXEL) begin
                    fs_we    = 1'b1;
                    fs_wdata = n_mod;
                    rd_we    = 1'b1;
                end
            end
            S_SRCH: begin
                rd_re = (r_row_ptr < Y_W'(PANEL_HEIGHT));
            end
            S_SRCH_CHK: begin
                if (rd_q) begin
                    rd_we    = 1'b1;
                    rd_waddr = r_row_ptr[DA_W-1:0];
                    rd_wdata = 1'b0;
                end
            end
            S_LINE, S_PCLR: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_FILL;
            r_fill       <= '0;
            r_vcom       <= 1'b1;
            r_scan_row   <= '0;
            r_byte_pos   <= '0;
            r_row_active <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_FILL: begin
                    r_fill <= r_fill + FC_W'(1);
                    if (r_fill == FC_W'(FILL_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_bit_idx <= n_bit_idx;
                        r_y       <= i_pixel_y;
                        r_on      <= i_pixel_on;
                        r_op      <= i_operation;
                        unique case (i_operation)
                            OP_SET_PIXEL: begin
                                if (in_range) begin
                                    r_state <= S_PIX_RD;
                                end
                            end
                            OP_GET_PIXEL: begin
                                if (in_range) begin
                                    r_state <= S_PIX_RD;
                                end else begin
                                    r_valid <= 1'b1;
                                    r_res   <= mk_result(KIND_PIXEL, 8'h00, 1'b0, 1'b0, 1'b0);
                                end
                            end
                            OP_CLEAR_STORE: begin
                                r_fill  <= '0;
                                r_state <= S_FILL;
                            end
                            OP_REFRESH: begin
                                if (!r_row_active) begin
                                    r_row_ptr <= r_scan_row;
                                    r_state   <= S_SRCH;
                                end else if (r_byte_pos == POS_W'(POS_ADDR)) begin
                                    r_valid    <= 1'b1;
                                    r_res      <= mk_result(KIND_SPI,
                                                      flip8(BYTE_W'(r_scan_row + Y_W'(1))),
                                                      1'b0, 1'b0, 1'b0);
                                    r_byte_pos <= r_byte_pos + POS_W'(1);
                                end else if (pos_is_line) begin
                                    r_state <= S_LINE;
                                end else if (r_byte_pos == POS_W'(POS_DUMMY0)) begin
                                    r_valid    <= 1'b1;
                                    r_res      <= mk_result(KIND_SPI, 8'h00, 1'b0, 1'b0, 1'b0);
                                    r_byte_pos <= r_byte_pos + POS_W'(1);
                                end else begin
                                    r_valid      <= 1'b1;
                                    r_res        <= mk_result(KIND_SPI, 8'h00, 1'b0, 1'b0, 1'b1);
                                    r_row_active <= 1'b0;
                                    r_byte_pos   <= '0;
                                    r_scan_row   <= r_scan_row + Y_W'(1);
                                end
                            end
                            OP_PANEL_CLEAR: begin
                                r_row_active <= 1'b0;
                                r_byte_pos   <= '0;
                                r_valid      <= 1'b1;
                                r_res        <= mk_result(KIND_SPI, hdr_byte(CMD_CLEAR, r_vcom),
                                                          1'b0, 1'b1, 1'b0);
                                r_state      <= S_PCLR;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_PIX_RD: begin
                    r_state <= S_PIX_MOD;
                end
                S_PIX_MOD: begin
                    if (r_op == OP_GET_PIXEL) begin
                        r_valid <= 1'b1;
                        r_res   <= mk_result(KIND_PIXEL, 8'h00, fs_q[r_bit_idx[2:0]],
                                             1'b0, 1'b0);
                    end
                    r_state <= S_IDLE;
                end
                S_SRCH: begin
                    if (r_row_ptr >= Y_W'(PANEL_HEIGHT)) begin
                        r_vcom     <= ~r_vcom;
                        r_scan_row <= '0;
                        r_valid    <= 1'b1;
                        r_res      <= mk_result(KIND_FRAME_DONE, 8'h00, 1'b0, 1'b0, 1'b1);
                        r_state    <= S_IDLE;
                    end else begin
                        r_state <= S_SRCH_CHK;
                    end
                end
                S_SRCH_CHK: begin
                    if (rd_q) begin
                        r_scan_row   <= r_row_ptr;
                        r_row_active <= 1'b1;
                        r_byte_pos   <= POS_W'(POS_ADDR);
                        r_row_base   <= n_row_base;
                        r_valid      <= 1'b1;
                        r_res        <= mk_result(KIND_SPI, hdr_byte(CMD_WRITE, r_vcom),
                                                  1'b0, 1'b1, 1'b0);
                        r_state      <= S_IDLE;
                    end else begin
                        r_row_ptr <= r_row_ptr + Y_W'(1);
                        r_state   <= S_SRCH;
                    end
                end
                S_LINE: begin
                    r_valid    <= 1'b1;
                    r_res      <= mk_result(KIND_SPI, flip8(fs_q), 1'b0, 1'b0, 1'b0);
                    r_byte_pos <= r_byte_pos + POS_W'(1);
                    r_state    <= S_IDLE;
                end
                S_PCLR: begin
                    r_valid <= 1'b1;
                    r_res   <= mk_result(KIND_SPI, 8'h00, 1'b0, 1'b0, 1'b1);
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    mlcd_ram #(
        .WIDTH  (BYTE_W),
        .DEPTH  (STORE_BYTES),
        .ADDR_W (FA_W)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (fs_we),
        .i_waddr (fs_waddr),
        .i_wdata (fs_wdata),
        .i_re    (fs_re),
        .i_raddr (fs_raddr),
        .o_rdata (fs_q)
    );

    mlcd_ram #(
        .WIDTH  (1),
        .DEPTH  (PANEL_HEIGHT),
        .ADDR_W (DA_W)
    ) u_dirty_ram (
        .i_clk   (i_clk),
        .i_we    (rd_we),
        .i_waddr (rd_waddr),
        .i_wdata (rd_wdata),
        .i_re    (rd_re),
        .i_raddr (rd_raddr),
        .o_rdata (rd_q)
    );

    assign busy                = (r_state != S_IDLE);
    assign o_valid             = r_valid;
    assign o_result_kind       = r_res.kind;
    assign o_spi_byte          = r_res.spi_byte;
    assign o_read_bit          = r_res.read_bit;
    assign o_first_of_transfer = r_res.first;
    assign o_last_of_transfer  = r_res.last;

endmodule

### hdl/mlcd_checker.sv
// port-level checker for the memory lcd frame controller, bound to the top level
`include "memory_lcd_frame_controller_top_assert.svh"

module mlcd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [mlcd_pkg::OP_W-1:0]   i_operation,
    input logic                        o_valid,
    input logic [mlcd_pkg::KIND_W-1:0] o_result_kind,
    input logic [mlcd_pkg::BYTE_W-1:0] o_spi_byte,
    input logic                        o_read_bit,
    input logic                        o_first_of_transfer,
    input logic                        o_last_of_transfer
);

    import mlcd_pkg::*;

    `MLCD_ASSERT_NOW(a_word_has_cause, o_valid, $past(start && !busy) || $past(busy), "result word without a command")
    `MLCD_ASSERT_NOW(a_frame_done_form, o_valid && o_result_kind == KIND_FRAME_DONE, o_last_of_transfer && !o_first_of_transfer && o_spi_byte == 8'h00 && !o_read_bit, "bad frame done word")
    `MLCD_ASSERT_NEXT(a_pclr_head, start && !busy && i_operation == OP_PANEL_CLEAR, o_valid && o_first_of_transfer && o_result_kind == KIND_SPI, "panel clear header missing")
    `MLCD_ASSERT_NOW(a_pclr_tail, $past(start && !busy && i_operation == OP_PANEL_CLEAR, 2), o_valid && o_last_of_transfer && o_spi_byte == 8'h00, "panel clear tail missing")

endmodule

bind memory_lcd_frame_controller_top mlcd_checker u_mlcd_checker (.*);
